// ----- hw/rtl/mp2d_pkg.sv -----
// Shared constants, types and a helper function for the strided 2-D max pooling block.
// Has no dependencies of its own; imported by max_pool_2d_strided and its testbench.
`default_nettype none

package mp2d_pkg;

    // Sizing of the block.
    localparam int MAX_WIDTH    = 64;
    localparam int MAX_KERNEL   = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int HEIGHT_LIMIT = 64;
    localparam int LINE_ROWS    = MAX_KERNEL - 1;

    // Derived widths.
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_BITS  = $clog2(LINE_ROWS);
    localparam int OFF_BITS   = $clog2(MAX_KERNEL);
    localparam int WIN_CELLS  = MAX_KERNEL * MAX_KERNEL;
    localparam int CELL_BITS  = $clog2(WIN_CELLS);
    localparam int KREG_BITS  = 3;
    localparam int SREG_BITS  = 3;
    localparam int DIM_BITS   = 7;

    // Reciprocal multiply used for the small quotients by the stride.
    localparam int RECIP_SHIFT = 9;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = ROW_BITS + RECIP_BITS;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd0;
    localparam logic [1:0] CFG_STRIDE       = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // One candidate of the maximum search: value and its row-major cell number.
    typedef struct packed {
        t_sample              val;
        logic [CELL_BITS-1:0] idx;
    } t_cand;

    // One result item.
    typedef struct packed {
        t_sample             pooled_value;
        logic [OFF_BITS-1:0] max_row_offset;
        logic [OFF_BITS-1:0] max_col_offset;
        logic [ROW_BITS-1:0] out_row;
        logic [COL_BITS-1:0] out_col;
        logic                last_of_frame;
    } t_result;

    // Rounded-up 2^RECIP_SHIFT / s for s in 1..7. For dividends below 64 the
    // top bits of v * recip(s) give v / s exactly, and the low bits fall
    // below recip(s) exactly when s divides v.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [SREG_BITS-1:0] s);
        logic [RECIP_BITS-1:0] r;
        r = '0;
        case (s)
            3'd2:    r = 10'd256;
            3'd3:    r = 10'd171;
            3'd4:    r = 10'd128;
            3'd5:    r = 10'd103;
            3'd6:    r = 10'd86;
            3'd7:    r = 10'd74;
            default: r = 10'd512;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/max_pool_2d_strided.sv -----
// Strided 2-D max pooling over one feature-map channel streamed in raster order.
// An accepted item's result passes the stage 1, stage 2 and output registers to o_valid.
// Throughput: one item per cycle while o_stall is low; all line memories are read, one written.
// A two-entry output stage keeps the input open while one result waits to be taken.
// Reset clears the row and column counters and loads kernel 2, stride 2, 28 x 28;
// the line memories and window registers are not cleared and are never read unwritten.
// Depends on mp2d_pkg.
`default_nettype none

module max_pool_2d_strided
    import mp2d_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    // Sample input channel.
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [SAMPLE_BITS-1:0] i_sample,

    // Result output channel.
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [SAMPLE_BITS-1:0] o_pooled_value,
    output logic [OFF_BITS-1:0]  o_max_row_offset,
    output logic [OFF_BITS-1:0]  o_max_col_offset,
    output logic [ROW_BITS-1:0]  o_out_row,
    output logic [COL_BITS-1:0]  o_out_col,
    output logic                 o_last_of_frame,

    // Configuration write channel.
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [DIM_BITS-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [KREG_BITS-1:0] r_kernel_size;
    logic [SREG_BITS-1:0] r_stride;
    logic [DIM_BITS-1:0]  r_image_width;
    logic [DIM_BITS-1:0]  r_image_height;

    logic [KREG_BITS-1:0] k_eff;
    logic [KREG_BITS-1:0] k_m1;
    logic [SREG_BITS-1:0] s_eff;
    logic [DIM_BITS-1:0]  w_eff;
    logic [DIM_BITS-1:0]  h_eff;

    logic                 en;
    logic                 acc;

    logic [ROW_BITS-1:0]  r_row;
    logic [COL_BITS-1:0]  r_col;
    logic [SLOT_BITS-1:0] r_slot;

    // Stage 1: registered sample and line memory reads.
    logic                 r_v1;
    t_sample              r_x1;
    logic [ROW_BITS-1:0]  r_row1;
    logic [COL_BITS-1:0]  r_col1;
    logic [SLOT_BITS-1:0] r_slot1;
    t_sample              r_rd [LINE_ROWS];

    // Stage 2: window registers and result position.
    t_sample              r_win [MAX_KERNEL][MAX_KERNEL];
    t_sample              col_val [MAX_KERNEL];
    logic                 r_v2;
    logic [ROW_BITS-1:0]  r_orow2;
    logic [COL_BITS-1:0]  r_ocol2;
    logic                 r_last2;

    logic [DIM_BITS-1:0]  row_span;
    logic [DIM_BITS-1:0]  col_span;
    logic [DIM_BITS-1:0]  row_base;
    logic [DIM_BITS-1:0]  col_base;
    logic [DIM_BITS-1:0]  h_base;
    logic [DIM_BITS-1:0]  w_base;
    logic [RECIP_BITS-1:0] rcp;
    logic [PROD_BITS-1:0] prod_r;
    logic [PROD_BITS-1:0] prod_c;
    logic [PROD_BITS-1:0] prod_h;
    logic [PROD_BITS-1:0] prod_w;
    logic [ROW_BITS-1:0]  orow;
    logic [COL_BITS-1:0]  ocol;
    logic                 emit;

    // Stage 3: maximum search and output buffer.
    t_cand                lvl0 [WIN_CELLS];
    t_cand                lvl1 [WIN_CELLS/2];
    t_cand                lvl2 [WIN_CELLS/4];
    t_cand                lvl3 [WIN_CELLS/8];
    t_cand                best;
    t_result              n_result;
    t_result              r_out;
    t_result              r_skid;
    logic                 r_out_valid;
    logic                 r_skid_valid;

    // ------------------------------------------------------------------
    // Configuration registers and their effective values
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size  <= KREG_BITS'(2);
            r_stride       <= SREG_BITS'(2);
            r_image_width  <= DIM_BITS'(28);
            r_image_height <= DIM_BITS'(28);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KERNEL_SIZE:  r_kernel_size  <= i_cfg_data[KREG_BITS-1:0];
                CFG_STRIDE:       r_stride       <= i_cfg_data[SREG_BITS-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Out-of-range settings are clamped to the nearest legal value.
    always_comb begin
        if (r_kernel_size == '0) begin
            k_eff = KREG_BITS'(1);
        end else if (r_kernel_size > KREG_BITS'(MAX_KERNEL)) begin
            k_eff = KREG_BITS'(MAX_KERNEL);
        end else begin
            k_eff = r_kernel_size;
        end
        k_m1  = k_eff - KREG_BITS'(1);
        s_eff = (r_stride == '0) ? SREG_BITS'(1) : r_stride;
        if (r_image_width == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (r_image_width > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = DIM_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = DIM_BITS'(1);
        end else if (r_image_height > DIM_BITS'(HEIGHT_LIMIT)) begin
            h_eff = DIM_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_image_height;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves unless the output skid entry is full.
    // ------------------------------------------------------------------
    assign en      = !r_skid_valid;
    assign acc     = i_valid && en;
    assign o_stall = r_skid_valid;

    // ------------------------------------------------------------------
    // Raster position of the next item and its line memory slot
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (acc) begin
            if (({1'b0, r_col} + DIM_BITS'(1)) >= w_eff) begin
                r_col <= '0;
                if (({1'b0, r_row} + DIM_BITS'(1)) >= h_eff) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + ROW_BITS'(1);
                    r_slot <= (r_slot == SLOT_BITS'(LINE_ROWS - 1)) ? '0
                                                                    : r_slot + SLOT_BITS'(1);
                end
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memories: one per slot, each read at the item's column; only the item's slot is written.
    // The read returns the old contents, which a full-height kernel needs.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < LINE_ROWS; g++) begin : g_line
        t_sample r_line [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (acc) begin
                if (r_slot == SLOT_BITS'(g)) begin
                    r_line[r_col] <= i_sample;
                end
                r_rd[g] <= r_line[r_col];
            end
        end
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x1    <= i_sample;
            r_row1  <= r_row;
            r_col1  <= r_col;
            r_slot1 <= r_slot;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: new window column, window shift and result position
    // ------------------------------------------------------------------
    // Window row i takes the line holding image row (row - (k-1-i)).
    always_comb begin
        logic [KREG_BITS-1:0] back;
        logic [KREG_BITS-1:0] sum;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            back = k_m1 - KREG_BITS'(i);
            sum  = {1'b0, r_slot1} + KREG_BITS'(LINE_ROWS) - back;
            if (sum >= KREG_BITS'(LINE_ROWS)) begin
                sum = sum - KREG_BITS'(LINE_ROWS);
            end
            if (KREG_BITS'(i) < k_m1) begin
                col_val[i] = r_rd[sum[SLOT_BITS-1:0]];
            end else begin
                col_val[i] = r_x1;
            end
        end
    end

    // The k x k window shifts left by one column per item.
    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            for (int i = 0; i < MAX_KERNEL; i++) begin
                if (KREG_BITS'(i) < k_eff) begin
                    for (int j = 0; j < MAX_KERNEL - 1; j++) begin
                        if (KREG_BITS'(j) < k_m1) begin
                            r_win[i][j] <= r_win[i][j+1];
                        end
                    end
                    for (int j = 0; j < MAX_KERNEL; j++) begin
                        if (KREG_BITS'(j) == k_m1) begin
                            r_win[i][j] <= col_val[i];
                        end
                    end
                end
            end
        end
    end

    // Window origin, output indexes and the stride-grid test.
    always_comb begin
        row_span = {1'b0, r_row1} + DIM_BITS'(1);
        col_span = {1'b0, r_col1} + DIM_BITS'(1);
        row_base = row_span - DIM_BITS'(k_eff);
        col_base = col_span - DIM_BITS'(k_eff);
        h_base   = h_eff - DIM_BITS'(k_eff);
        w_base   = w_eff - DIM_BITS'(k_eff);
        rcp      = recip(s_eff);
        prod_r   = PROD_BITS'(row_base[ROW_BITS-1:0]) * PROD_BITS'(rcp);
        prod_c   = PROD_BITS'(col_base[COL_BITS-1:0]) * PROD_BITS'(rcp);
        prod_h   = PROD_BITS'(h_base[ROW_BITS-1:0]) * PROD_BITS'(rcp);
        prod_w   = PROD_BITS'(w_base[COL_BITS-1:0]) * PROD_BITS'(rcp);
        orow     = prod_r[RECIP_SHIFT +: ROW_BITS];
        ocol     = prod_c[RECIP_SHIFT +: COL_BITS];
        emit     = (row_span >= DIM_BITS'(k_eff)) && (col_span >= DIM_BITS'(k_eff))
                && ({1'b0, r_row1} < h_eff) && ({1'b0, r_col1} < w_eff)
                && (RECIP_BITS'(prod_r[RECIP_SHIFT-1:0]) < rcp)
                && (RECIP_BITS'(prod_c[RECIP_SHIFT-1:0]) < rcp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1 && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            r_orow2 <= orow;
            r_ocol2 <= ocol;
            r_last2 <= (orow == prod_h[RECIP_SHIFT +: ROW_BITS])
                    && (ocol == prod_w[RECIP_SHIFT +: COL_BITS]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: maximum over the window in row-major order.
    // Cells outside the kernel hold the most negative value; as cell (0,0)
    // always lies inside and comes first, they can never win. The right
    // candidate wins only when strictly greater, so the first maximum stays.
    // ------------------------------------------------------------------
    always_comb begin
        for (int n = 0; n < WIN_CELLS; n++) begin
            lvl0[n].idx = CELL_BITS'(n);
            if ((KREG_BITS'(n / MAX_KERNEL) < k_eff) && (KREG_BITS'(n % MAX_KERNEL) < k_eff)) begin
                lvl0[n].val = r_win[n / MAX_KERNEL][n % MAX_KERNEL];
            end else begin
                lvl0[n].val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
        end
        for (int n = 0; n < WIN_CELLS/2; n++) begin
            lvl1[n] = (lvl0[2*n+1].val > lvl0[2*n].val) ? lvl0[2*n+1] : lvl0[2*n];
        end
        for (int n = 0; n < WIN_CELLS/4; n++) begin
            lvl2[n] = (lvl1[2*n+1].val > lvl1[2*n].val) ? lvl1[2*n+1] : lvl1[2*n];
        end
        for (int n = 0; n < WIN_CELLS/8; n++) begin
            lvl3[n] = (lvl2[2*n+1].val > lvl2[2*n].val) ? lvl2[2*n+1] : lvl2[2*n];
        end
        best = (lvl3[1].val > lvl3[0].val) ? lvl3[1] : lvl3[0];

        n_result.pooled_value   = best.val;
        n_result.max_row_offset = best.idx[CELL_BITS-1 -: OFF_BITS];
        n_result.max_col_offset = best.idx[OFF_BITS-1:0];
        n_result.out_row        = r_orow2;
        n_result.out_col        = r_ocol2;
        n_result.last_of_frame  = r_last2;
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry behind it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_v2;
        end else if (r_v2) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out <= n_result;
        end else if (r_v2) begin
            r_skid <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pooled_value   = r_out.pooled_value;
    assign o_max_row_offset = r_out.max_row_offset;
    assign o_max_col_offset = r_out.max_col_offset;
    assign o_out_row        = r_out.out_row;
    assign o_out_col        = r_out.out_col;
    assign o_last_of_frame  = r_out.last_of_frame;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid entry only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register is empty");

    // An accepted item inside a row advances the column by one.
    a_col_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (({1'b0, r_col} + DIM_BITS'(1)) < w_eff)) |=> (r_col == $past(r_col) + COL_BITS'(1)))
        else $error("column counter did not advance");

    // The first row of a frame always uses the first line slot.
    a_slot_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0) |-> (r_slot == '0))
        else $error("line slot out of step with the row counter");

    // No item enters while the output side is backed up.
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_skid_valid && i_stall) |=> !$past(acc))
        else $error("item accepted while the skid entry was full");

endmodule

`default_nettype wire

// ----- dv/tb_max_pool_2d_strided.sv -----
// Self-checking testbench for max_pool_2d_strided: streams feature-map frames and
// checks every pooled value against a cycle-free predictor kept in step with the items.
// Depends on mp2d_pkg and max_pool_2d_strided.
`timescale 1ns / 100ps

module tb_max_pool_2d_strided
    import mp2d_pkg::*;
();

    typedef enum int {FILL_FULL, FILL_NARROW, FILL_EDGES} t_fill;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic [SAMPLE_BITS-1:0] o_pooled_value;
    logic [OFF_BITS-1:0]    o_max_row_offset;
    logic [OFF_BITS-1:0]    o_max_col_offset;
    logic [ROW_BITS-1:0]    o_out_row;
    logic [COL_BITS-1:0]    o_out_col;
    logic                   o_last_of_frame;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [DIM_BITS-1:0]    i_cfg_data;

    max_pool_2d_strided u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pooled_value   (o_pooled_value),
        .o_max_row_offset (o_max_row_offset),
        .o_max_col_offset (o_max_col_offset),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_last_of_frame  (o_last_of_frame),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Predictor state: register copies, line memories, window and raster position.
    logic [KREG_BITS-1:0] kernel_reg;
    logic [SREG_BITS-1:0] stride_reg;
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    t_sample              line_mem [LINE_ROWS][MAX_WIDTH];
    t_sample              win_regs [MAX_KERNEL][MAX_KERNEL];
    int                   row_pos;
    int                   col_pos;

    t_result pooled_q [$];
    int      mismatches;
    int      samples_sent;
    int      send_idle_pct;
    int      recv_stall_pct;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // The receiver stalls at random, at the rate of the current idling phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Back to the state after reset: default registers, cleared stores, origin.
    function automatic void pool_reset();
        kernel_reg = 3'd2;
        stride_reg = 3'd2;
        width_reg  = 7'd28;
        height_reg = 7'd28;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        foreach (win_regs[i, j]) win_regs[i][j] = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    // Advance the predictor by one sample and queue the pooled value it completes.
    function automatic void pool_predict(input t_sample x);
        int      k, s, w, h, r, c, i, j, br, bc, orow, ocol, slot;
        t_sample col_vals [MAX_KERNEL];
        t_sample best;
        t_result res;
        k = (kernel_reg == 0) ? 1 : ((kernel_reg > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_reg));
        s = (stride_reg == 0) ? 1 : int'(stride_reg);
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg));
        r = row_pos;
        c = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;

        // New window column: the k-1 rows above from the line memories, then the sample.
        for (i = 0; i < k - 1; i++) begin
            slot = (r + LINE_ROWS * 64 - (k - 1 - i)) % LINE_ROWS;
            col_vals[i] = line_mem[slot][c];
        end
        col_vals[k-1] = x;
        line_mem[r % LINE_ROWS][c] = x;

        // Shift the window one column left and insert the new column on the right.
        for (i = 0; i < k; i++) begin
            for (j = 0; j < k - 1; j++) win_regs[i][j] = win_regs[i][j+1];
            win_regs[i][k-1] = col_vals[i];
        end

        // A window on the stride grid is complete: strict compare, first maximum wins.
        if (r + 1 >= k && c + 1 >= k && r < h && c < w &&
                (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
            best = win_regs[0][0];
            br = 0;
            bc = 0;
            for (i = 0; i < k; i++) begin
                for (j = 0; j < k; j++) begin
                    if (win_regs[i][j] > best) begin
                        best = win_regs[i][j];
                        br = i;
                        bc = j;
                    end
                end
            end
            orow = (r + 1 - k) / s;
            ocol = (c + 1 - k) / s;
            res.pooled_value   = best;
            res.max_row_offset = OFF_BITS'(br);
            res.max_col_offset = OFF_BITS'(bc);
            res.out_row        = ROW_BITS'(orow);
            res.out_col        = COL_BITS'(ocol);
            res.last_of_frame  = (orow == (h - k) / s) && (ocol == (w - k) / s);
            pooled_q.push_back(res);
        end

        // Raster advance; a position past a reduced limit wraps at the next advance.
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic t_sample gen_sample(input t_fill style);
        t_sample v;
        case (style)
            FILL_NARROW: v = t_sample'(int'($urandom_range(0, 4)) - 2);
            FILL_EDGES: begin
                case ($urandom_range(0, 3))
                    0:       v = SAMPLE_MIN;
                    1:       v = SAMPLE_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default:     v = t_sample'($urandom);
        endcase
        return v;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Every accepted result is checked against the oldest pooled value still owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pooled_q.size() == 0) begin
                $error("pooled_value: no result expected, got %0d", $signed(o_pooled_value));
                mismatches++;
            end else begin
                want = pooled_q.pop_front();
                check_field("pooled_value", int'(want.pooled_value),
                            int'($signed(o_pooled_value)));
                check_field("max_row_offset", int'(want.max_row_offset),
                            int'(o_max_row_offset));
                check_field("max_col_offset", int'(want.max_col_offset),
                            int'(o_max_col_offset));
                check_field("out_row", int'(want.out_row), int'(o_out_row));
                check_field("out_col", int'(want.out_col), int'(o_out_col));
                check_field("last_of_frame", int'(want.last_of_frame), int'(o_last_of_frame));
            end
        end
    end

    // Offer one sample after a random gap and hold it until the block takes it.
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pool_predict(s);
        samples_sent++;
    endtask

    // Send samples until the raster position is back at the origin.
    task automatic send_frame(input t_fill style);
        do send_sample(gen_sample(style));
        while (row_pos != 0 || col_pos != 0);
    endtask

    // Release the input, wait for every owed result, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DIM_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KERNEL_SIZE:  kernel_reg = val[KREG_BITS-1:0];
            CFG_STRIDE:       stride_reg = val[SREG_BITS-1:0];
            CFG_IMAGE_WIDTH:  width_reg  = val;
            CFG_IMAGE_HEIGHT: height_reg = val;
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Registers are only written once the block has nothing left in flight.
    task automatic apply_config(input logic [DIM_BITS-1:0] kd, input logic [DIM_BITS-1:0] sd,
                                input logic [DIM_BITS-1:0] wd, input logic [DIM_BITS-1:0] hd);
        wait_drained();
        cfg_write(CFG_KERNEL_SIZE, kd);
        cfg_write(CFG_STRIDE, sd);
        cfg_write(CFG_IMAGE_WIDTH, wd);
        cfg_write(CFG_IMAGE_HEIGHT, hd);
    endtask

    task automatic set_idling(input t_idle mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 84; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            IDLE_BOTH:     begin send_idle_pct = 27; recv_stall_pct = 27; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Two rows of a 28 x 28 frame under the registers as they come out of reset.
    task automatic test_reset_defaults();
        repeat (56) send_sample(gen_sample(FILL_FULL));
    endtask

    // Shrinking the image mid-frame wraps the counters at the next item.
    task automatic test_midframe_wrap();
        apply_config(7'd2, 7'd2, 7'd1, 7'd1);
        send_frame(FILL_FULL);
    endtask

    // Extreme sample values and ties in a 2 x 2 window.
    task automatic test_sample_extremes();
        apply_config(7'd2, 7'd2, 7'd2, 7'd2);
        repeat (4) send_sample(SAMPLE_MIN);
        send_sample('1);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
    endtask

    // Kernel and stride of zero both act as one; the upper data bits are ignored.
    task automatic test_unit_kernel();
        apply_config(7'b1011000, 7'b0100000, 7'd3, 7'd1);
        send_frame(FILL_FULL);
    endtask

    // A kernel above the largest acts as the largest; maximum in the far corner.
    task automatic test_kernel_clamp();
        apply_config(7'd7, 7'd4, 7'd4, 7'd4);
        repeat (15) send_sample(gen_sample(FILL_NARROW));
        send_sample(t_sample'(100));
        send_frame(FILL_NARROW);
    endtask

    // A stride beyond four is used as given.
    task automatic test_wide_stride();
        apply_config(7'd1, 7'd5, 7'd6, 7'd2);
        send_frame(FILL_FULL);
    endtask

    // A window larger than the image gives no result, but the frame still ends.
    task automatic test_oversized_window();
        apply_config(7'd4, 7'd1, 7'd3, 7'd5);
        send_frame(FILL_FULL);
    endtask

    // Width above the limit acts as the limit, reaching the last output column.
    task automatic test_width_clamp();
        apply_config(7'd1, 7'd1, 7'd127, 7'd1);
        send_frame(FILL_FULL);
    endtask

    // Width zero acts as one; height above the limit reaches the last output row.
    task automatic test_height_clamp();
        apply_config(7'd1, 7'd1, 7'd0, 7'd127);
        send_frame(FILL_FULL);
    endtask

    // After a full 6 x 3 frame with a 3 x 3 kernel every store is written, so a smaller
    // kernel and width may take over mid-frame; those windows mix the old and new layout.
    task automatic test_midframe_kernel();
        apply_config(7'd3, 7'd1, 7'd6, 7'd3);
        send_frame(FILL_NARROW);
        repeat (8) send_sample(gen_sample(FILL_FULL));
        apply_config(7'd2, 7'd1, 7'd5, 7'd3);
        send_frame(FILL_NARROW);
    endtask

    // Whole frames under random settings, mostly small images with the odd extreme.
    task automatic test_random_frames(input t_idle mode, input int n_items);
        int                  start;
        int                  pick;
        logic [DIM_BITS-1:0] kd, sd, wd, hd;
        set_idling(mode);
        start = samples_sent;
        while (samples_sent - start < n_items) begin
            kd = DIM_BITS'($urandom);
            sd = DIM_BITS'($urandom);
            if ($urandom_range(0, 9) < 7) kd[2:0] = 3'($urandom_range(1, MAX_KERNEL));
            if ($urandom_range(0, 9) < 8) sd[2:0] = 3'($urandom_range(1, 4));
            wd = DIM_BITS'($urandom_range(1, 12));
            hd = DIM_BITS'($urandom_range(1, 12));
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                wd = '0;
            end else if (pick == 1) begin
                hd = '0;
            end else if (pick == 2) begin
                wd = DIM_BITS'($urandom_range(13, 127));
                hd = DIM_BITS'($urandom_range(0, 3));
            end else if (pick == 3) begin
                hd = DIM_BITS'($urandom_range(13, 127));
                wd = DIM_BITS'($urandom_range(0, 3));
            end
            apply_config(kd, sd, wd, hd);
            send_frame(t_fill'($urandom_range(0, 2)));
        end
    endtask

    // Reset once, directed cases, then random frames through each idling phase.
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_KERNEL_SIZE;
        i_cfg_data   = '0;
        mismatches   = 0;
        samples_sent = 0;
        set_idling(IDLE_NONE);
        pool_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_defaults();
        test_midframe_wrap();
        test_sample_extremes();
        test_unit_kernel();
        test_kernel_clamp();
        test_wide_stride();
        test_oversized_window();
        test_width_clamp();
        test_height_clamp();
        test_midframe_kernel();
        test_random_frames(IDLE_NONE, 100);
        test_random_frames(IDLE_SENDER, 100);
        test_random_frames(IDLE_RECEIVER, 100);
        test_random_frames(IDLE_BOTH, 100);
        wait_drained();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mp2d_pkg.sv
hw/rtl/max_pool_2d_strided.sv
dv/tb_max_pool_2d_strided.sv
